/* rtl/core/tlbfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_pkg
// Command codes and decoded operation kinds shared by the TLB front and back.
// ----------------------------------------------------------------------------
package tlbfa_pkg;

  localparam int CMD_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_UNSET  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_SET_RO = 2'd3;

  localparam int OP_KIND_BITS = 4;

  typedef enum logic [OP_KIND_BITS-1:0] {
    OP_LOOKUP = 4'b0001,
    OP_ADD    = 4'b0010,
    OP_UNSET  = 4'b0100,
    OP_SET_RO = 4'b1000
  } op_kind_t;

endpackage

/* rtl/core/tlbfa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_req_if
// Command channel into the TLB: valid/ready with command, page, frame, flag.
// ----------------------------------------------------------------------------
interface tlbfa_req_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic [tlbfa_pkg::CMD_BITS-1:0] cmd;
  logic [PAGE_BITS-1:0]          page;
  logic [FRAME_BITS-1:0]         frame;
  logic                          ro_flag;

  modport source (output valid, cmd, page, frame, ro_flag, input ready);
  modport sink   (input valid, cmd, page, frame, ro_flag, output ready);
endinterface

/* rtl/core/tlbfa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_rsp_if
// Result channel out of the TLB: valid/ready with hit, frame and readonly.
// ----------------------------------------------------------------------------
interface tlbfa_rsp_if #(
  parameter int FRAME_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] hit_frame;
  logic                  hit_readonly;

  modport source (output valid, hit, hit_frame, hit_readonly, input ready);
  modport sink   (input valid, hit, hit_frame, hit_readonly, output ready);
endinterface

/* rtl/core/tlbfa_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_queue
// Two-entry decoupling queue between the command front and the TLB back.
// ----------------------------------------------------------------------------
module tlbfa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/tlbfa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_front
// Takes command transfers, decodes the command into an operation kind and
// hands the packed operation to the queue.
// ----------------------------------------------------------------------------
module tlbfa_front #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 12,
  parameter int WIDTH      = tlbfa_pkg::OP_KIND_BITS + PAGE_BITS + FRAME_BITS + 1
) (
  tlbfa_req_if.sink        req,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [WIDTH-1:0] push_data
);

  typedef struct packed {
    tlbfa_pkg::op_kind_t   kind;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  ro;
  } item_t;

  item_t item;

  always_comb begin
    item.page  = req.page;
    item.frame = req.frame;
    item.ro    = req.ro_flag;
    unique case (req.cmd)
      tlbfa_pkg::CMD_LOOKUP: item.kind = tlbfa_pkg::OP_LOOKUP;
      tlbfa_pkg::CMD_ADD:    item.kind = tlbfa_pkg::OP_ADD;
      tlbfa_pkg::CMD_UNSET:  item.kind = tlbfa_pkg::OP_UNSET;
      default:               item.kind = tlbfa_pkg::OP_SET_RO;
    endcase
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;
  assign push_data  = item;

endmodule

/* rtl/core/tlbfa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfa_back
// Entry store and command execution: parallel tag match, counter ageing,
// fill of the first free entry and a serial scan for the oldest victim.
// ----------------------------------------------------------------------------
module tlbfa_back #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 12,
  parameter int AGE_BITS   = 16,
  parameter int WIDTH      = tlbfa_pkg::OP_KIND_BITS + PAGE_BITS + FRAME_BITS + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [WIDTH-1:0] pop_data,
  tlbfa_rsp_if.source      rsp
);

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  typedef struct packed {
    tlbfa_pkg::op_kind_t   kind;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  ro;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t                state;
  state_t                state_next;
  item_t                 cur;
  logic [PAGE_BITS-1:0]  tag [ENTRIES];
  logic [AGE_BITS-1:0]   age [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [ENTRIES-1:0]    ro;
  logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
  logic [FRAME_BITS-1:0] rd_frame;
  logic                  hit_r;
  logic                  hro_r;
  logic [IDX_BITS-1:0]   scan_idx;
  logic [AGE_BITS-1:0]   best;
  logic [IDX_BITS-1:0]   slot;

  logic [ENTRIES-1:0]    tag_eq;
  logic                  any_match;
  logic                  any_tag;
  logic                  any_free;
  logic [IDX_BITS-1:0]   match_idx;
  logic [IDX_BITS-1:0]   tag_idx;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  out_free;
  logic                  take;
  logic                  scan_gt;
  logic [IDX_BITS-1:0]   final_slot;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_idx;
  logic                  is_lookup;
  logic                  is_add;

  assign is_lookup = (cur.kind == tlbfa_pkg::OP_LOOKUP);
  assign is_add    = (cur.kind == tlbfa_pkg::OP_ADD);

  // first-entry priority encoders, lowest index wins
  always_comb begin
    any_match = 1'b0;
    any_tag   = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    tag_idx   = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      tag_eq[i] = (tag[i] == cur.page);
      if (tag_eq[i] && valid[i]) begin
        any_match = 1'b1;
        match_idx = IDX_BITS'(i);
      end
      if (tag_eq[i]) begin
        any_tag = 1'b1;
        tag_idx = IDX_BITS'(i);
      end
      if (!valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign out_free   = !rsp.valid || rsp.ready;
  assign pop_ready  = (state == S_IDLE) || ((state == S_RESP) && out_free);
  assign take       = pop_valid && pop_ready;
  assign scan_gt    = (age[scan_idx] > best);
  assign final_slot = scan_gt ? scan_idx : slot;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_idx;
    if ((state == S_EXEC) && is_add && any_free) begin
      wr_en = 1'b1;
    end else if ((state == S_SCAN) && (scan_idx == LAST_IDX)) begin
      wr_en  = 1'b1;
      wr_idx = final_slot;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (is_add && !any_free) ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = take ? S_EXEC : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pop_data;
    end
  end

  // victim scan: strictly greater wins, so the first entry keeps a tie
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      scan_idx <= '0;
      best     <= '0;
      slot     <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_gt) begin
        best <= age[scan_idx];
        slot <= scan_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_idx] <= cur.frame;
    end
    if (state == S_EXEC) begin
      rd_frame <= frame_mem[match_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      hit_r <= is_lookup && any_match;
      hro_r <= ro[match_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ro    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag[i] <= '0;
        age[i] <= '0;
      end
    end else begin
      if ((state == S_EXEC) && is_lookup) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (any_match && (match_idx == IDX_BITS'(i))) begin
            age[i] <= '0;
          end else if (age[i] != AGE_MAX) begin
            age[i] <= age[i] + 1'b1;
          end
        end
      end
      if ((state == S_EXEC) && (cur.kind == tlbfa_pkg::OP_UNSET) && any_tag) begin
        valid[tag_idx] <= 1'b0;
      end
      if ((state == S_EXEC) && (cur.kind == tlbfa_pkg::OP_SET_RO) && any_tag) begin
        ro[tag_idx] <= cur.ro;
      end
      if (wr_en) begin
        tag[wr_idx]   <= cur.page;
        age[wr_idx]   <= '0;
        valid[wr_idx] <= 1'b1;
        ro[wr_idx]    <= cur.ro;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      rsp.hit          <= hit_r;
      rsp.hit_frame    <= hit_r ? rd_frame : '0;
      rsp.hit_readonly <= hit_r && hro_r;
    end
  end

endmodule

/* rtl/core/tlb_fully_assoc_lru_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fully_assoc_lru_counter
// Fully associative TLB with saturating ageing counters for replacement.
// ----------------------------------------------------------------------------
// Commands are handled one at a time: the back executes a command, then
// responds, and takes the next one from the queue only once idle or as its
// response goes out; an add into a full table also runs a serial scan over
// the ageing counters for the victim.
// Reset clears the queue, valid bits, tags, readonly flags and counters;
// the frame store is not cleared and needs no clearing pass.
module tlb_fully_assoc_lru_counter #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 12,
  parameter int AGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  tlbfa_req_if.sink   req,
  tlbfa_rsp_if.source rsp
);

  localparam int ITEM_BITS = tlbfa_pkg::OP_KIND_BITS + PAGE_BITS + FRAME_BITS + 1;

  logic                 push_valid;
  logic                 push_ready;
  logic [ITEM_BITS-1:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [ITEM_BITS-1:0] pop_data;

  tlbfa_front #(
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .WIDTH      (ITEM_BITS)
  ) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tlbfa_queue #(
    .WIDTH (ITEM_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tlbfa_back #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .AGE_BITS   (AGE_BITS),
    .WIDTH      (ITEM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

endmodule
